// ===== sv/ssc_pkg.sv =====
// ssc_pkg: shared types and constants for the set subset and sum check block
// used by ssc_cell and set_subset_and_sum_check; no dependencies
package ssc_pkg;

  localparam int DATA_W       = 32;
  localparam int DEF_CAPACITY = 64;

  typedef enum logic [1:0] {
    ACT_CLEAR    = 2'd0,
    ACT_APPEND_A = 2'd1,
    ACT_APPEND_B = 2'd2,
    ACT_EVAL     = 2'd3
  } act_t;

  // element travelling around the ring during evaluation
  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              vld;
    logic              hit;
  } rot_t;

  // per-cycle commands from the controller to every cell
  typedef struct packed {
    logic shift_a;
    logic shift_b;
    logic load;
    logic rotate;
  } cell_ctl_t;

endpackage

// ===== sv/set_subset_and_sum_check.sv =====
// set_subset_and_sum_check: top level, list append control, sums and ring evaluation
// clear and append items leave busy low; busy stays low and the next start is taken
// an evaluate item holds busy while the ring makes two laps;
// out_valid rises in the same cycle as busy falls
// results cannot be stalled; synchronous active-low reset empties both lists
// depends on ssc_pkg and ssc_cell
module set_subset_and_sum_check #(
  parameter int CAPACITY = ssc_pkg::DEF_CAPACITY
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_action,
  input  logic signed [ssc_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  output logic signed [ssc_pkg::DATA_W-1:0] out_sum_a,
  output logic signed [ssc_pkg::DATA_W-1:0] out_sum_b,
  output logic                              out_a_within_b,
  output logic                              out_b_within_a,
  output logic                              out_overflowed
);
  import ssc_pkg::*;

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int STEP_W = $clog2(2 * CAPACITY);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t            state_r;
  logic [STEP_W-1:0] stp_r;
  logic [CNT_W-1:0]  cnt_a_r;
  logic [CNT_W-1:0]  cnt_b_r;
  logic [DATA_W-1:0] sum_a_r;
  logic [DATA_W-1:0] sum_b_r;
  logic              drop_r;
  logic              ok_ab_r;
  logic              ok_ba_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_sum_a_r;
  logic [DATA_W-1:0] out_sum_b_r;
  logic              out_ab_r;
  logic              out_ba_r;
  logic              out_ovf_r;

  logic              accept;
  act_t              act;
  logic              full_a;
  logic              full_b;
  logic              chk;
  logic              last;
  logic              ok_ab_nxt;
  logic              ok_ba_nxt;
  cell_ctl_t         ctl;

  logic [DATA_W-1:0] a_chain [CAPACITY];
  logic [DATA_W-1:0] b_chain [CAPACITY];
  rot_t              ra_o    [CAPACITY];
  rot_t              rb_o    [CAPACITY];

  assign busy   = (state_r == ST_RUN);
  assign accept = start & ~busy;
  assign act    = act_t'(in_action);
  assign full_a = (cnt_a_r == CNT_W'(CAPACITY));
  assign full_b = (cnt_b_r == CNT_W'(CAPACITY));

  always_comb begin
    ctl.shift_a = accept & (act == ACT_APPEND_A) & ~full_a;
    ctl.shift_b = accept & (act == ACT_APPEND_B) & ~full_b;
    ctl.load    = accept & (act == ACT_EVAL);
    ctl.rotate  = busy;
  end

  // second lap: each element leaving the last cell has met every resident element
  assign chk       = busy & (stp_r >= STEP_W'(CAPACITY));
  assign last      = busy & (stp_r == STEP_W'(2 * CAPACITY - 1));
  assign ok_ab_nxt = ok_ab_r & ~(chk & ra_o[CAPACITY-1].vld & ~ra_o[CAPACITY-1].hit);
  assign ok_ba_nxt = ok_ba_r & ~(chk & rb_o[CAPACITY-1].vld & ~rb_o[CAPACITY-1].hit);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] a_in;
    logic [DATA_W-1:0] b_in;
    if (i == 0) begin : g_head
      assign a_in = $unsigned(in_value);
      assign b_in = $unsigned(in_value);
    end else begin : g_body
      assign a_in = a_chain[i-1];
      assign b_in = b_chain[i-1];
    end
    ssc_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .cnt_a  (cnt_a_r),
      .cnt_b  (cnt_b_r),
      .a_in   (a_in),
      .b_in   (b_in),
      .a_out  (a_chain[i]),
      .b_out  (b_chain[i]),
      .ra_in  (ra_o[(i + CAPACITY - 1) % CAPACITY]),
      .rb_in  (rb_o[(i + CAPACITY - 1) % CAPACITY]),
      .ra_out (ra_o[i]),
      .rb_out (rb_o[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stp_r       <= '0;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      sum_a_r     <= '0;
      sum_b_r     <= '0;
      drop_r      <= 1'b0;
      ok_ab_r     <= 1'b1;
      ok_ba_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= last;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            unique case (act)
              ACT_CLEAR: begin
                cnt_a_r <= '0;
                cnt_b_r <= '0;
                sum_a_r <= '0;
                sum_b_r <= '0;
                drop_r  <= 1'b0;
              end
              ACT_APPEND_A: begin
                if (full_a) begin
                  drop_r <= 1'b1;
                end else begin
                  cnt_a_r <= cnt_a_r + CNT_W'(1);
                  sum_a_r <= sum_a_r + $unsigned(in_value);
                end
              end
              ACT_APPEND_B: begin
                if (full_b) begin
                  drop_r <= 1'b1;
                end else begin
                  cnt_b_r <= cnt_b_r + CNT_W'(1);
                  sum_b_r <= sum_b_r + $unsigned(in_value);
                end
              end
              ACT_EVAL: begin
                state_r <= ST_RUN;
                stp_r   <= '0;
                ok_ab_r <= 1'b1;
                ok_ba_r <= 1'b1;
              end
              default: begin
                state_r <= ST_IDLE;
              end
            endcase
          end
        end
        ST_RUN: begin
          ok_ab_r <= ok_ab_nxt;
          ok_ba_r <= ok_ba_nxt;
          stp_r   <= stp_r + STEP_W'(1);
          if (last) begin
            state_r     <= ST_IDLE;
            out_sum_a_r <= sum_a_r;
            out_sum_b_r <= sum_b_r;
            out_ab_r    <= ok_ab_nxt;
            out_ba_r    <= ok_ba_nxt;
            out_ovf_r   <= drop_r;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sum_a      = $signed(out_sum_a_r);
  assign out_sum_b      = $signed(out_sum_b_r);
  assign out_a_within_b = out_ab_r;
  assign out_b_within_a = out_ba_r;
  assign out_overflowed = out_ovf_r;

  a_result_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_RUN))
    else $error("result transfer without evaluation");

  a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy during result transfer");

  a_eval_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && act == ACT_EVAL) |=> busy)
    else $error("evaluate transfer did not start the ring");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_a_r <= CNT_W'(CAPACITY)) && (cnt_b_r <= CNT_W'(CAPACITY)))
    else $error("list count beyond capacity");

endmodule

// ===== sv/ssc_cell.sv =====
// ssc_cell: one cell of the ring, holds one element of each list and one
// travelling element of each list; depends on ssc_pkg
module ssc_cell #(
  parameter int CNT_W = 7,
  parameter int IDX   = 0
) (
  input  logic                              clk,
  input  ssc_pkg::cell_ctl_t                ctl,
  input  logic [CNT_W-1:0]                  cnt_a,
  input  logic [CNT_W-1:0]                  cnt_b,
  input  logic [ssc_pkg::DATA_W-1:0]        a_in,
  input  logic [ssc_pkg::DATA_W-1:0]        b_in,
  output logic [ssc_pkg::DATA_W-1:0]        a_out,
  output logic [ssc_pkg::DATA_W-1:0]        b_out,
  input  ssc_pkg::rot_t                     ra_in,
  input  ssc_pkg::rot_t                     rb_in,
  output ssc_pkg::rot_t                     ra_out,
  output ssc_pkg::rot_t                     rb_out
);
  import ssc_pkg::*;

  logic [DATA_W-1:0] a_val_r;
  logic [DATA_W-1:0] b_val_r;
  rot_t              ra_r;
  rot_t              rb_r;
  logic              a_vld;
  logic              b_vld;

  assign a_vld = CNT_W'(IDX) < cnt_a;
  assign b_vld = CNT_W'(IDX) < cnt_b;

  always_ff @(posedge clk) begin
    if (ctl.shift_a) begin
      a_val_r <= a_in;
    end
    if (ctl.shift_b) begin
      b_val_r <= b_in;
    end
    if (ctl.load) begin
      ra_r <= '{val: a_val_r, vld: a_vld, hit: 1'b0};
      rb_r <= '{val: b_val_r, vld: b_vld, hit: 1'b0};
    end else if (ctl.rotate) begin
      ra_r <= ra_in;
      rb_r <= rb_in;
    end
  end

  assign a_out = a_val_r;
  assign b_out = b_val_r;

  // travelling a element meets the resident b element and vice versa
  always_comb begin
    ra_out     = ra_r;
    ra_out.hit = ra_r.hit | (b_vld & (ra_r.val == b_val_r));
    rb_out     = rb_r;
    rb_out.hit = rb_r.hit | (a_vld & (rb_r.val == a_val_r));
  end

endmodule

// ===== tb/set_subset_and_sum_check_tb.sv =====
`timescale 1ns / 100ps
// set_subset_and_sum_check_tb: self-checking bench for the list subset and sum block
// tracks both lists, their sums and the drop flag, and checks every evaluate result
// depends on ssc_pkg and set_subset_and_sum_check
module set_subset_and_sum_check_tb;
  import ssc_pkg::*;

  localparam int CAP         = DEF_CAPACITY;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_PRINTS  = 60;

  typedef struct packed {
    logic [DATA_W-1:0] sum_a;
    logic [DATA_W-1:0] sum_b;
    logic              a_in_b;
    logic              b_in_a;
    logic              ovf;
  } verdict_t;

  logic                     clk;
  logic                     rst_n     = 1'b0;
  logic                     start     = 1'b0;
  logic [1:0]               in_action = ACT_CLEAR;
  logic signed [DATA_W-1:0] in_value  = '0;
  logic                     busy;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_sum_a;
  logic signed [DATA_W-1:0] out_sum_b;
  logic                     out_a_within_b;
  logic                     out_b_within_a;
  logic                     out_overflowed;

  // tracked copy of the block state
  logic [DATA_W-1:0] held_a [CAP];
  logic [DATA_W-1:0] held_b [CAP];
  int                n_a     = 0;
  int                n_b     = 0;
  logic [DATA_W-1:0] total_a = '0;
  logic [DATA_W-1:0] total_b = '0;
  logic              dropped = 1'b0;

  verdict_t verdicts_due[$];
  verdict_t head_verdict;
  int       idle_pct    = 0;
  int       n_sent      = 0;
  int       err_count   = 0;
  int       cycle_count = 0;

  set_subset_and_sum_check #(.CAPACITY(CAP)) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_sum_a      (out_sum_a),
    .out_sum_b      (out_sum_b),
    .out_a_within_b (out_a_within_b),
    .out_b_within_a (out_b_within_a),
    .out_overflowed (out_overflowed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    if (err_count < MAX_PRINTS)
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    err_count++;
  endtask

  function automatic bit all_found(bit from_a);
    int                src_n;
    int                dst_n;
    logic [DATA_W-1:0] key;
    bit                hit;
    src_n = from_a ? n_a : n_b;
    dst_n = from_a ? n_b : n_a;
    for (int i = 0; i < src_n; i++) begin
      key = from_a ? held_a[i] : held_b[i];
      hit = 1'b0;
      for (int j = 0; j < dst_n; j++)
        if ((from_a ? held_b[j] : held_a[j]) == key) hit = 1'b1;
      if (!hit) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic track_lists(act_t act, logic [DATA_W-1:0] v);
    verdict_t vd;
    case (act)
      ACT_CLEAR: begin
        n_a     = 0;
        n_b     = 0;
        total_a = '0;
        total_b = '0;
        dropped = 1'b0;
      end
      ACT_APPEND_A: begin
        if (n_a < CAP) begin
          held_a[n_a] = v;
          n_a++;
          total_a += v;
        end else begin
          dropped = 1'b1;
        end
      end
      ACT_APPEND_B: begin
        if (n_b < CAP) begin
          held_b[n_b] = v;
          n_b++;
          total_b += v;
        end else begin
          dropped = 1'b1;
        end
      end
      default: begin
        vd.sum_a  = total_a;
        vd.sum_b  = total_b;
        vd.a_in_b = all_found(1'b1);
        vd.b_in_a = all_found(1'b0);
        vd.ovf    = dropped;
        verdicts_due.push_back(vd);
      end
    endcase
  endtask

  // start stays high from one transfer to the next unless the sender idles
  task automatic send_item(act_t act, logic [DATA_W-1:0] v);
    while ($urandom_range(0, 99) < idle_pct) begin
      start     <= 1'b0;
      in_action <= $urandom_range(0, 3);
      in_value  <= $urandom;
      @(posedge clk);
    end
    start     <= 1'b1;
    in_action <= act;
    in_value  <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    track_lists(act, v);
    n_sent++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (verdicts_due.size() == 0) begin
        report_mismatch("result with nothing pending", out_sum_a, '0);
      end else begin
        head_verdict = verdicts_due.pop_front();
        if (out_sum_a !== head_verdict.sum_a)
          report_mismatch("sum_a", out_sum_a, head_verdict.sum_a);
        if (out_sum_b !== head_verdict.sum_b)
          report_mismatch("sum_b", out_sum_b, head_verdict.sum_b);
        if (out_a_within_b !== head_verdict.a_in_b)
          report_mismatch("a_within_b", out_a_within_b, head_verdict.a_in_b);
        if (out_b_within_a !== head_verdict.b_in_a)
          report_mismatch("b_within_a", out_b_within_a, head_verdict.b_in_a);
        if (out_overflowed !== head_verdict.ovf)
          report_mismatch("overflowed", out_overflowed, head_verdict.ovf);
      end
    end
  end

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_lists();
    send_item(ACT_EVAL, $urandom);
    send_item(ACT_APPEND_B, '0);
    send_item(ACT_EVAL, $urandom);
    send_item(ACT_CLEAR, '1);
    send_item(ACT_EVAL, $urandom);
  endtask

  task automatic test_extremes();
    send_item(ACT_CLEAR, $urandom);
    send_item(ACT_APPEND_A, 32'h7FFF_FFFF);
    send_item(ACT_APPEND_A, 32'h8000_0000);
    send_item(ACT_APPEND_A, 32'hFFFF_FFFF);
    send_item(ACT_APPEND_A, 32'h0000_0001);
    send_item(ACT_APPEND_B, 32'h0000_0001);
    send_item(ACT_APPEND_B, 32'hFFFF_FFFF);
    send_item(ACT_APPEND_B, 32'h8000_0000);
    send_item(ACT_APPEND_B, 32'h7FFF_FFFF);
    send_item(ACT_EVAL, '1);
    // one bit away from an element of a
    send_item(ACT_APPEND_B, 32'h7FFF_FFFE);
    send_item(ACT_EVAL, '0);
  endtask

  task automatic test_duplicates();
    logic [DATA_W-1:0] x;
    x = $urandom;
    send_item(ACT_CLEAR, '0);
    send_item(ACT_APPEND_A, x);
    send_item(ACT_APPEND_A, x);
    send_item(ACT_APPEND_B, x);
    send_item(ACT_EVAL, $urandom);
    send_item(ACT_APPEND_B, x ^ 32'h8000_0000);
    send_item(ACT_EVAL, $urandom);
  endtask

  // fill both lists past capacity; the drop flag holds across evaluates until clear
  task automatic test_capacity();
    logic [DATA_W-1:0] fill[$];
    send_item(ACT_CLEAR, $urandom);
    for (int i = 0; i < CAP + 2; i++) begin
      fill.push_back(rand_word());
      send_item(ACT_APPEND_A, fill[i]);
    end
    send_item(ACT_EVAL, $urandom);
    for (int i = CAP - 1; i >= 0; i--) send_item(ACT_APPEND_B, fill[i]);
    send_item(ACT_EVAL, $urandom);
    send_item(ACT_APPEND_B, fill[0]);
    send_item(ACT_EVAL, $urandom);
    send_item(ACT_CLEAR, $urandom);
    send_item(ACT_EVAL, $urandom);
  endtask

  // lists drawn from one pool: a within b when ka <= kb, b within a when kb <= ka,
  // unless a stray word breaks it or the clear before loading is skipped
  task automatic load_and_evaluate();
    logic [DATA_W-1:0] pool[8];
    logic [DATA_W-1:0] seq_a[$];
    logic [DATA_W-1:0] seq_b[$];
    logic [DATA_W-1:0] stray;
    int                ka;
    int                kb;
    int                extra_a;
    int                extra_b;
    bit                take_a;
    for (int k = 0; k < 8; k++) pool[k] = rand_word();
    ka      = $urandom_range(0, 8);
    kb      = $urandom_range(0, 8);
    extra_a = ($urandom_range(0, 24) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 6);
    extra_b = ($urandom_range(0, 24) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 6);
    for (int k = 0; k < ka; k++) seq_a.insert($urandom_range(0, seq_a.size()), pool[k]);
    for (int k = 0; k < kb; k++) seq_b.insert($urandom_range(0, seq_b.size()), pool[k]);
    if (ka > 0)
      for (int k = 0; k < extra_a; k++)
        seq_a.insert($urandom_range(0, seq_a.size()), pool[$urandom_range(0, ka - 1)]);
    if (kb > 0)
      for (int k = 0; k < extra_b; k++)
        seq_b.insert($urandom_range(0, seq_b.size()), pool[$urandom_range(0, kb - 1)]);
    if ($urandom_range(0, 3) == 0) begin
      stray = $urandom_range(0, 1) ? $urandom : pool[$urandom_range(0, 7)] ^ (1 << $urandom_range(0, 31));
      if ($urandom_range(0, 1)) seq_a.insert($urandom_range(0, seq_a.size()), stray);
      else seq_b.insert($urandom_range(0, seq_b.size()), stray);
    end
    if ($urandom_range(0, 9) != 0) send_item(ACT_CLEAR, $urandom);
    while (seq_a.size() != 0 || seq_b.size() != 0) begin
      take_a = (seq_b.size() == 0) || (seq_a.size() != 0 && $urandom_range(0, 1));
      if (take_a) send_item(ACT_APPEND_A, seq_a.pop_front());
      else send_item(ACT_APPEND_B, seq_b.pop_front());
      if ($urandom_range(0, 24) == 0) send_item(ACT_EVAL, $urandom);
    end
    send_item(ACT_EVAL, $urandom);
    if ($urandom_range(0, 4) == 0) send_item(ACT_EVAL, $urandom);
  endtask

  task automatic test_random(int pct, int goal);
    idle_pct = pct;
    while (n_sent < goal) load_and_evaluate();
  endtask

  initial begin
    idle_pct = 18;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_lists();
    test_extremes();
    test_duplicates();
    test_capacity();
    test_random(18, 700);
    test_random(51, 1250);
    test_random(0, 1750);
    start <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (2 * CAP + 8) @(posedge clk);
    if (err_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== set_subset_and_sum_check.f =====
sv/ssc_pkg.sv
sv/ssc_cell.sv
sv/set_subset_and_sum_check.sv
tb/set_subset_and_sum_check_tb.sv
